// ===== rtl/navigation_mission_supervisor_fsm_defines.svh =====
// Assertion macros shared by the RTL
`ifndef NAVIGATION_MISSION_SUPERVISOR_FSM_DEFINES_SVH
`define NAVIGATION_MISSION_SUPERVISOR_FSM_DEFINES_SVH

`ifndef SYNTHESIS
`define NAVMS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("navms assertion failed");
`define NAVMS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("navms assertion failed");
`else
`define NAVMS_ASSERT(label, clk, rst_n, prop)
`define NAVMS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/navms_pkg.sv =====
package navms_pkg;

  localparam int unsigned StatWidthDef = 32;
  localparam int unsigned CntWidth     = 8;
  localparam int unsigned TotWidth     = 32;
  localparam int unsigned CfgIdxWidth  = 1;

  typedef enum logic [2:0] {
    StIdle    = 3'd0,
    StPlan    = 3'd1,
    StFollow  = 3'd2,
    StReached = 3'd3,
    StRecover = 3'd4,
    StFailed  = 3'd5
  } state_e;

  typedef enum logic [3:0] {
    EvGoal       = 4'd0,
    EvPlanOk     = 4'd1,
    EvPlanFail   = 4'd2,
    EvReached    = 4'd3,
    EvBlocked    = 4'd4,
    EvStuck      = 4'd5,
    EvFollowFail = 4'd6,
    EvOdomJump   = 4'd7,
    EvRecDone    = 4'd8,
    EvRecFail    = 4'd9,
    EvCancel     = 4'd10
  } event_e;

  typedef enum logic [2:0] {
    FxNone    = 3'd0,
    FxPlan    = 3'd1,
    FxFollow  = 3'd2,
    FxStop    = 3'd3,
    FxRecover = 3'd4
  } effect_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgPlanRetryLimit = 1'd0,
    CfgRecoveryLimit  = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic    ok;
    state_e  nxt;
    effect_e fx;
  } trans_t;

  localparam trans_t TransNone = '{ok: 1'b0, nxt: StIdle, fx: FxNone};

  function automatic trans_t mk(state_e nxt, effect_e fx);
    trans_t t;
    t.ok  = 1'b1;
    t.nxt = nxt;
    t.fx  = fx;
    return t;
  endfunction

  // Base transition table, before retry limits are applied.
  function automatic trans_t trans_lookup(state_e st, logic [3:0] ev);
    trans_t t;
    t = TransNone;
    case (st)
      StIdle, StReached, StFailed: begin
        case (ev)
          EvGoal:   t = mk(StPlan, FxPlan);
          EvCancel: t = mk(StIdle, FxNone);
          default:  t = TransNone;
        endcase
      end
      StPlan: begin
        case (ev)
          EvGoal:     t = mk(StPlan, FxPlan);
          EvPlanOk:   t = mk(StFollow, FxFollow);
          EvPlanFail: t = mk(StFailed, FxStop);
          EvCancel:   t = mk(StIdle, FxStop);
          default:    t = TransNone;
        endcase
      end
      StFollow: begin
        case (ev)
          EvGoal, EvOdomJump:  t = mk(StPlan, FxPlan);
          EvReached:           t = mk(StReached, FxStop);
          EvBlocked, EvStuck:  t = mk(StRecover, FxStop);
          EvFollowFail:        t = mk(StFailed, FxStop);
          EvCancel:            t = mk(StIdle, FxStop);
          default:             t = TransNone;
        endcase
      end
      StRecover: begin
        case (ev)
          EvReached:          t = mk(StReached, FxStop);
          EvBlocked, EvStuck: t = mk(StRecover, FxStop);
          EvRecDone:          t = mk(StFollow, FxFollow);
          EvRecFail:          t = mk(StFailed, FxStop);
          EvCancel:           t = mk(StIdle, FxStop);
          default:            t = TransNone;
        endcase
      end
      default: t = TransNone;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/navigation_mission_supervisor_fsm.sv =====
// Each event beat that is taken yields a registered result beat in the next cycle.
// Throughput: one event per cycle; the result register is the only stage,
// and a new event is taken whenever that register is empty or being drained.
// Reset: asynchronous, active low; state returns to idle, counters and totals
// clear, both limits return to 3, no result is pending.
`include "navigation_mission_supervisor_fsm_defines.svh"

module navigation_mission_supervisor_fsm #(
  parameter int unsigned StatWidth = navms_pkg::StatWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [navms_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [navms_pkg::CntWidth-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [3:0]                          event_code_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                accepted_o,
  output logic [2:0]                          from_state_o,
  output logic [2:0]                          to_state_o,
  output logic [2:0]                          effect_o,
  output logic [navms_pkg::CntWidth-1:0]      recoveries_used_o,
  output logic [navms_pkg::CntWidth-1:0]      plan_fail_run_o,
  output logic [navms_pkg::TotWidth-1:0]      plan_fail_total_o,
  output logic [navms_pkg::TotWidth-1:0]      recovery_total_o,
  output logic [navms_pkg::TotWidth-1:0]      plan_request_total_o
);

  localparam int unsigned CntW = navms_pkg::CntWidth;
  localparam int unsigned TotW = navms_pkg::TotWidth;

  navms_pkg::state_e     state_q, state_d;
  logic [CntW-1:0]       plan_retry_limit_q, recovery_limit_q;
  logic [CntW-1:0]       rec_cnt_q, rec_cnt_d;
  logic [CntW-1:0]       pf_cnt_q, pf_cnt_d;
  logic [StatWidth-1:0]  pf_sum_q, pf_sum_d;
  logic [StatWidth-1:0]  rec_sum_q, rec_sum_d;
  logic [StatWidth-1:0]  req_sum_q, req_sum_d;

  logic                  out_valid_q;
  logic                  accepted_q, accepted_d;
  navms_pkg::state_e     from_q;
  navms_pkg::state_e     to_q, to_d;
  navms_pkg::effect_e    fx_q, fx_d;
  logic [CntW-1:0]       rec_used_q, pf_run_q;
  logic [StatWidth-1:0]  pf_tot_q, rec_tot_q, req_tot_q;

  navms_pkg::trans_t     ent;
  logic                  in_fire, out_fire;
  logic                  pf_inc, rec_inc, req_inc;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_retry_limit_q <= CntW'(3);
      recovery_limit_q   <= CntW'(3);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (navms_pkg::cfg_reg_e'(cfg_index_i))
        navms_pkg::CfgPlanRetryLimit: plan_retry_limit_q <= cfg_data_i;
        navms_pkg::CfgRecoveryLimit:  recovery_limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ent        = navms_pkg::trans_lookup(state_q, event_code_i);
    state_d    = state_q;
    to_d       = state_q;
    fx_d       = navms_pkg::FxNone;
    accepted_d = ent.ok;
    rec_cnt_d  = rec_cnt_q;
    pf_cnt_d   = pf_cnt_q;
    pf_inc     = 1'b0;
    rec_inc    = 1'b0;
    req_inc    = 1'b0;
    if (ent.ok) begin
      to_d = ent.nxt;
      fx_d = ent.fx;
      case (state_q)
        navms_pkg::StIdle, navms_pkg::StReached, navms_pkg::StFailed: begin
          if (event_code_i == navms_pkg::EvGoal) begin
            rec_cnt_d = '0;
            pf_cnt_d  = '0;
          end
        end
        navms_pkg::StPlan: begin
          if (event_code_i == navms_pkg::EvPlanOk) begin
            pf_cnt_d = '0;
          end else if (event_code_i == navms_pkg::EvPlanFail) begin
            if (pf_cnt_q != '1) begin
              pf_cnt_d = pf_cnt_q + CntW'(1);
            end
            pf_inc = 1'b1;
            if (pf_cnt_d <= plan_retry_limit_q) begin
              to_d = navms_pkg::StPlan;
              fx_d = navms_pkg::FxPlan;
            end
          end
        end
        navms_pkg::StFollow: begin
          if (event_code_i == navms_pkg::EvBlocked || event_code_i == navms_pkg::EvStuck) begin
            if (rec_cnt_q >= recovery_limit_q) begin
              to_d = navms_pkg::StFailed;
              fx_d = navms_pkg::FxStop;
            end else begin
              rec_cnt_d = rec_cnt_q + CntW'(1);
              rec_inc   = 1'b1;
            end
          end
        end
        navms_pkg::StRecover: begin
          if (event_code_i == navms_pkg::EvRecFail && rec_cnt_q < recovery_limit_q) begin
            rec_cnt_d = rec_cnt_q + CntW'(1);
            rec_inc   = 1'b1;
            to_d      = navms_pkg::StRecover;
            fx_d      = navms_pkg::FxRecover;
          end
        end
        default: ;
      endcase
      req_inc = (to_d == navms_pkg::StPlan) && (fx_d == navms_pkg::FxPlan);
      state_d = to_d;
    end
    pf_sum_d  = (pf_inc && pf_sum_q != '1) ? pf_sum_q + StatWidth'(1) : pf_sum_q;
    rec_sum_d = (rec_inc && rec_sum_q != '1) ? rec_sum_q + StatWidth'(1) : rec_sum_q;
    req_sum_d = (req_inc && req_sum_q != '1) ? req_sum_q + StatWidth'(1) : req_sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= navms_pkg::StIdle;
      rec_cnt_q <= '0;
      pf_cnt_q  <= '0;
      pf_sum_q  <= '0;
      rec_sum_q <= '0;
      req_sum_q <= '0;
    end else if (in_fire) begin
      state_q   <= state_d;
      rec_cnt_q <= rec_cnt_d;
      pf_cnt_q  <= pf_cnt_d;
      pf_sum_q  <= pf_sum_d;
      rec_sum_q <= rec_sum_d;
      req_sum_q <= req_sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      accepted_q <= accepted_d;
      from_q     <= state_q;
      to_q       <= to_d;
      fx_q       <= fx_d;
      rec_used_q <= rec_cnt_d;
      pf_run_q   <= pf_cnt_d;
      pf_tot_q   <= pf_sum_d;
      rec_tot_q  <= rec_sum_d;
      req_tot_q  <= req_sum_d;
    end
  end

  // totals are reported in the low bits, zero-extended when narrower
  logic [StatWidth+TotW-1:0] pf_tot_ext, rec_tot_ext, req_tot_ext;
  assign pf_tot_ext  = {TotW'(0), pf_tot_q};
  assign rec_tot_ext = {TotW'(0), rec_tot_q};
  assign req_tot_ext = {TotW'(0), req_tot_q};

  assign out_valid_o          = out_valid_q;
  assign accepted_o           = accepted_q;
  assign from_state_o         = from_q;
  assign to_state_o           = to_q;
  assign effect_o             = fx_q;
  assign recoveries_used_o    = rec_used_q;
  assign plan_fail_run_o      = pf_run_q;
  assign plan_fail_total_o    = pf_tot_ext[TotW-1:0];
  assign recovery_total_o     = rec_tot_ext[TotW-1:0];
  assign plan_request_total_o = req_tot_ext[TotW-1:0];

  `NAVMS_ASSERT(a_reject_no_move, clk_i, rst_ni, out_valid_q && !accepted_q |-> to_q == from_q && fx_q == navms_pkg::FxNone)
  `NAVMS_ASSERT(a_state_tracks_result, clk_i, rst_ni, in_fire |=> out_valid_q && state_q == to_q)
  `NAVMS_ASSERT(a_idle_holds_state, clk_i, rst_ni, !in_fire |=> $stable(state_q) && $stable(rec_cnt_q) && $stable(pf_cnt_q))

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import navms_pkg::*;

  localparam logic [3:0]  EvBadLo       = 4'd11;
  localparam logic [3:0]  EvBadHi       = 4'd15;
  localparam logic [7:0]  LimitRstVal   = 8'd3;
  localparam int unsigned TimeoutCycles = 200_000;

  typedef struct packed {
    logic                acc;
    state_e              from_st;
    state_e              to_st;
    effect_e             fx;
    logic [CntWidth-1:0] rec_used;
    logic [CntWidth-1:0] pf_run;
    logic [TotWidth-1:0] pf_tot;
    logic [TotWidth-1:0] rec_tot;
    logic [TotWidth-1:0] req_tot;
  } mission_result_t;

  class mission_scoreboard;
    state_e              mission_st;
    logic [CntWidth-1:0] rec_used;
    logic [CntWidth-1:0] pf_run;
    logic [CntWidth-1:0] plan_lim;
    logic [CntWidth-1:0] rec_lim;
    logic [TotWidth-1:0] pf_sum;
    logic [TotWidth-1:0] rec_sum;
    logic [TotWidth-1:0] req_sum;
    mission_result_t     expected_q[$];
    int unsigned         errors;
    int unsigned         n_taken;

    function new();
      mission_st = StIdle;
      rec_used   = '0;
      pf_run     = '0;
      plan_lim   = LimitRstVal;
      rec_lim    = LimitRstVal;
      pf_sum     = '0;
      rec_sum    = '0;
      req_sum    = '0;
      errors     = 0;
      n_taken    = 0;
    endfunction

    function logic [TotWidth-1:0] bump(logic [TotWidth-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function void set_limit(cfg_reg_e idx, logic [CntWidth-1:0] val);
      case (idx)
        CfgPlanRetryLimit: plan_lim = val;
        CfgRecoveryLimit:  rec_lim  = val;
        default: ;
      endcase
    endfunction

    function void note_event(logic [3:0] ev);
      mission_result_t r;
      logic            ok;
      state_e          from_st;
      state_e          to_st;
      effect_e         fx;
      ok      = 1'b0;
      from_st = mission_st;
      to_st   = mission_st;
      fx      = FxNone;
      case (mission_st)
        StIdle, StReached, StFailed: begin
          if (ev == EvGoal) begin
            ok = 1'b1; to_st = StPlan; fx = FxPlan;
            rec_used = '0;
            pf_run   = '0;
          end else if (ev == EvCancel) begin
            ok = 1'b1; to_st = StIdle;
          end
        end
        StPlan: begin
          case (ev)
            EvGoal:   begin ok = 1'b1; to_st = StPlan; fx = FxPlan; end
            EvPlanOk: begin ok = 1'b1; to_st = StFollow; fx = FxFollow; pf_run = '0; end
            EvPlanFail: begin
              ok = 1'b1;
              if (pf_run != '1) pf_run = pf_run + 1'b1;
              pf_sum = bump(pf_sum);
              if (pf_run <= plan_lim) begin
                to_st = StPlan; fx = FxPlan;
              end else begin
                to_st = StFailed; fx = FxStop;
              end
            end
            EvCancel: begin ok = 1'b1; to_st = StIdle; fx = FxStop; end
            default: ;
          endcase
        end
        StFollow: begin
          case (ev)
            EvGoal, EvOdomJump: begin ok = 1'b1; to_st = StPlan; fx = FxPlan; end
            EvReached: begin ok = 1'b1; to_st = StReached; fx = FxStop; end
            EvBlocked, EvStuck: begin
              ok = 1'b1; fx = FxStop;
              if (rec_used >= rec_lim) begin
                to_st = StFailed;
              end else begin
                to_st    = StRecover;
                rec_used = rec_used + 1'b1;
                rec_sum  = bump(rec_sum);
              end
            end
            EvFollowFail: begin ok = 1'b1; to_st = StFailed; fx = FxStop; end
            EvCancel:     begin ok = 1'b1; to_st = StIdle; fx = FxStop; end
            default: ;
          endcase
        end
        StRecover: begin
          case (ev)
            EvReached: begin ok = 1'b1; to_st = StReached; fx = FxStop; end
            EvBlocked, EvStuck: begin ok = 1'b1; to_st = StRecover; fx = FxStop; end
            EvRecDone: begin ok = 1'b1; to_st = StFollow; fx = FxFollow; end
            EvRecFail: begin
              ok = 1'b1;
              if (rec_used < rec_lim) begin
                to_st    = StRecover; fx = FxRecover;
                rec_used = rec_used + 1'b1;
                rec_sum  = bump(rec_sum);
              end else begin
                to_st = StFailed; fx = FxStop;
              end
            end
            EvCancel: begin ok = 1'b1; to_st = StIdle; fx = FxStop; end
            default: ;
          endcase
        end
        default: ;
      endcase
      if (ok) begin
        if (to_st == StPlan && fx == FxPlan) req_sum = bump(req_sum);
        mission_st = to_st;
      end
      n_taken++;
      r.acc      = ok;
      r.from_st  = from_st;
      r.to_st    = to_st;
      r.fx       = fx;
      r.rec_used = rec_used;
      r.pf_run   = pf_run;
      r.pf_tot   = pf_sum;
      r.rec_tot  = rec_sum;
      r.req_tot  = req_sum;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("tb: mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(mission_result_t got);
      mission_result_t e;
      if (expected_q.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      if (got.acc !== e.acc)
        report($sformatf("accepted got %0h exp %0h", got.acc, e.acc));
      if (got.from_st !== e.from_st)
        report($sformatf("from_state got %0h exp %0h", got.from_st, e.from_st));
      if (got.to_st !== e.to_st)
        report($sformatf("to_state got %0h exp %0h", got.to_st, e.to_st));
      if (got.fx !== e.fx)
        report($sformatf("effect got %0h exp %0h", got.fx, e.fx));
      if (got.rec_used !== e.rec_used)
        report($sformatf("recoveries_used got %0h exp %0h", got.rec_used, e.rec_used));
      if (got.pf_run !== e.pf_run)
        report($sformatf("plan_fail_run got %0h exp %0h", got.pf_run, e.pf_run));
      if (got.pf_tot !== e.pf_tot)
        report($sformatf("plan_fail_total got %0h exp %0h", got.pf_tot, e.pf_tot));
      if (got.rec_tot !== e.rec_tot)
        report($sformatf("recovery_total got %0h exp %0h", got.rec_tot, e.rec_tot));
      if (got.req_tot !== e.req_tot)
        report($sformatf("plan_request_total got %0h exp %0h", got.req_tot, e.req_tot));
    endtask
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxWidth-1:0] cfg_index_i = CfgPlanRetryLimit;
  logic [CntWidth-1:0]    cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  logic [3:0]             event_code_i = EvGoal;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   accepted_o;
  logic [2:0]             from_state_o;
  logic [2:0]             to_state_o;
  logic [2:0]             effect_o;
  logic [CntWidth-1:0]    recoveries_used_o;
  logic [CntWidth-1:0]    plan_fail_run_o;
  logic [TotWidth-1:0]    plan_fail_total_o;
  logic [TotWidth-1:0]    recovery_total_o;
  logic [TotWidth-1:0]    plan_request_total_o;

  mission_scoreboard sb = new();
  mission_result_t   seen;
  int unsigned       cycle_cnt   = 0;
  int unsigned       stall_left  = 0;
  int unsigned       stall_mode  = 0;
  int unsigned       stall_phase = 0;

  navigation_mission_supervisor_fsm u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= TimeoutCycles) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_event(event_code_i);
      if (out_valid_o && !out_stall_i) begin
        seen.acc      = accepted_o;
        seen.from_st  = state_e'(from_state_o);
        seen.to_st    = state_e'(to_state_o);
        seen.fx       = effect_e'(effect_o);
        seen.rec_used = recoveries_used_o;
        seen.pf_run   = plan_fail_run_o;
        seen.pf_tot   = plan_fail_total_o;
        seen.rec_tot  = recovery_total_o;
        seen.req_tot  = plan_request_total_o;
        sb.check_result(seen);
      end
    end
  end

  // receiver: modes of no stall, sparse, periodic and heavy stalls
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(16, 96);
      stall_mode = $urandom_range(0, 3);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ((stall_phase % 5) < 2);
      default: out_stall_i <= ($urandom_range(0, 2) != 0);
    endcase
  end

  // leaves valid high; the caller lowers it
  task automatic send_event(logic [3:0] ev);
    in_valid_i   <= 1'b1;
    event_code_i <= ev;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic flush_results();
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_limits(logic [CntWidth-1:0] plan_lim, logic [CntWidth-1:0] rec_lim);
    flush_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgPlanRetryLimit;
    cfg_data_i  <= plan_lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_limit(CfgPlanRetryLimit, plan_lim);
    @(negedge clk_i);
    cfg_index_i <= CfgRecoveryLimit;
    cfg_data_i  <= rec_lim;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_limit(CfgRecoveryLimit, rec_lim);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly events the current state takes, some noise and bad codes
  function automatic logic [3:0] pick_event(state_e st);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 4'($urandom_range(EvBadLo, EvBadHi));
    if (r < 20) return 4'($urandom_range(EvGoal, EvCancel));
    r = $urandom_range(0, 9);
    case (st)
      StPlan: begin
        if (r < 4) return EvPlanFail;
        if (r < 8) return EvPlanOk;
        return (r == 8) ? EvGoal : EvCancel;
      end
      StFollow: begin
        case (r)
          0, 1, 2: return EvBlocked;
          3, 4:    return EvStuck;
          5:       return EvReached;
          6:       return EvOdomJump;
          7:       return EvFollowFail;
          8:       return EvGoal;
          default: return EvCancel;
        endcase
      end
      StRecover: begin
        case (r)
          0, 1, 2, 3: return EvRecFail;
          4, 5:       return EvRecDone;
          6:          return EvBlocked;
          7:          return EvStuck;
          8:          return EvReached;
          default:    return EvCancel;
        endcase
      end
      default: return (r < 8) ? EvGoal : EvCancel;
    endcase
  endfunction

  task automatic random_traffic(int unsigned target);
    int unsigned burst;
    while (sb.n_taken < target) begin
      burst = $urandom_range(1, 20);
      repeat (burst) send_event(pick_event(sb.mission_st));
      if ($urandom_range(0, 24) == 0) begin
        in_valid_i <= 1'b0;
        flush_results();
      end else if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    logic [3:0]          directed_evs[$];
    logic [CntWidth-1:0] plan_lims[5];
    logic [CntWidth-1:0] rec_lims[5];
    directed_evs = '{EvBadHi, EvPlanOk, EvCancel, EvGoal, EvGoal,
                     EvPlanFail, EvPlanFail, EvPlanFail, EvPlanFail,
                     EvGoal, EvPlanOk, EvOdomJump, EvPlanOk,
                     EvBlocked, EvStuck, EvRecFail, EvRecFail, EvRecFail,
                     EvCancel, EvGoal, EvPlanOk, EvStuck, EvRecDone,
                     EvReached, EvBadLo, EvGoal, EvCancel};
    plan_lims = '{8'd0, 8'd254, 8'd1, 8'd0, LimitRstVal};
    rec_lims  = '{8'd0, 8'd255, 8'd2, 8'd0, LimitRstVal};
    plan_lims[3] = CntWidth'($urandom_range(0, 6));
    rec_lims[3]  = CntWidth'($urandom_range(0, 6));

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_evs[i]) send_event(directed_evs[i]);
    in_valid_i <= 1'b0;

    for (int p = 0; p < 5; p++) begin
      set_limits(plan_lims[p], rec_lims[p]);
      if (p == 1) begin
        // run counter up to saturation, then recoveries up to the top limit
        send_event(EvCancel);
        send_event(EvGoal);
        repeat (255) send_event(EvPlanFail);
        send_event(EvGoal);
        send_event(EvPlanOk);
        send_event(EvBlocked);
        repeat (256) send_event(EvRecFail);
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
      random_traffic(sb.n_taken + 70);
    end

    flush_results();
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/navms_pkg.sv
rtl/navigation_mission_supervisor_fsm.sv
verif/tb.sv
